/* design/ffb5_pkg.sv */
// shared types, constants and kernel tables for the 5x5 feature filter bank
// no dependencies; imported by the top level and referenced by the bench
`default_nettype none

package ffb5_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIN       = 5;
    localparam int LINES     = WIN - 1;
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int CFG_W_W   = 11;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W     = 16;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(1024);
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(284);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic signed [SUM_W-1:0] psum_t;
    typedef int kern_t [WIN*WIN];

    localparam kern_t K_GRAD_U = '{
        1, 2, 0, -2, -1,
        4, 8, 0, -8, -4,
        6, 12, 0, -12, -6,
        4, 8, 0, -8, -4,
        1, 2, 0, -2, -1
    };
    localparam kern_t K_GRAD_V = '{
        1, 4, 6, 4, 1,
        2, 8, 12, 8, 2,
        0, 0, 0, 0, 0,
        -2, -8, -12, -8, -2,
        -1, -4, -6, -4, -1
    };
    localparam kern_t K_BLOB = '{
        -1, -1, -1, -1, -1,
        -1, 1, 1, 1, -1,
        -1, 1, 8, 1, -1,
        -1, 1, 1, 1, -1,
        -1, -1, -1, -1, -1
    };
    localparam kern_t K_CHECKER = '{
        -1, -1, 0, 1, 1,
        -1, -1, 0, 1, 1,
        0, 0, 0, 0, 0,
        1, 1, 0, -1, -1,
        1, 1, 0, -1, -1
    };

    // per-pixel bookkeeping that rides along the pipeline
    typedef struct packed {
        logic [COL_W-1:0] cc;
        logic [ROW_W-1:0] cr;
        logic             valid;
        logic             last;
    } meta_t;

endpackage

`default_nettype wire

/* design/feature_filter_bank_5x5_top.sv */
// 5x5 filter bank top: line store, window, gradient/blob/checker kernels
// path: an accepted pixel passes the column, window, row-total and output registers
// throughput: one pixel per clock unless the output stalls, set by one line ram
// read-modify-write per pixel (read on accept, stage 1 writes back; never same column)
// reset: counters, window and pipeline valids clear; line ram is not cleared
// depends on ffb5_pkg and ffb5_ram
`default_nettype none

module feature_filter_bank_5x5_top (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [ffb5_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] pixel
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [7:0] grad_u, [15:8] grad_v, [28:16] blob_response,
    // [40:29] checker_response, [50:41] center_col, [62:51] center_row, [63] zero
    output logic [63:0]                   m_tdata,
    output logic                          m_tuser,   // [0] window_valid
    output logic                          m_tlast    // frame_last
);

    import ffb5_pkg::*;

    localparam int RAM_W = LINES * PIX_W;

    // ---------------- configuration ----------------
    logic [CFG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFG_W_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CFG_W_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;

    always_comb
    begin
        if (width_reg < CFG_W_W'(5))
            w_eff = CFG_W_W'(5);
        else if (width_reg > CFG_W_W'(MAX_WIDTH))
            w_eff = CFG_W_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg < ROW_W'(5)) ? ROW_W'(5) : height_reg;
    end

    // ---------------- pipeline control ----------------
    logic out_vld_reg;
    logic adv;
    logic accept;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // ---------------- stage 0: position counters ----------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CFG_W_W-1:0] col_inc;
    logic [ROW_W:0]     row_inc;
    logic               row_end, frame_end;
    logic [CFG_W_W-1:0] cc_wide;
    logic signed [ROW_W+1:0] cr_raw, cr_fix;
    meta_t s0_meta;

    always_comb
    begin
        col_inc   = {1'b0, col_reg} + CFG_W_W'(1);
        row_inc   = {1'b0, row_reg} + (ROW_W+1)'(1);
        row_end   = col_inc >= w_eff;
        frame_end = row_inc >= {1'b0, h_eff};

        // centre sits two columns back; columns 0 and 1 fold into the previous row
        if (col_reg >= COL_W'(2))
        begin
            cc_wide = {1'b0, col_reg} - CFG_W_W'(2);
            cr_raw  = $signed({2'b00, row_reg}) - (ROW_W+2)'(2);
        end
        else
        begin
            cc_wide = {1'b0, col_reg} + w_eff - CFG_W_W'(2);
            cr_raw  = $signed({2'b00, row_reg}) - (ROW_W+2)'(3);
        end
        cr_fix = (cr_raw < 0) ? cr_raw + $signed({2'b00, h_eff}) : cr_raw;

        s0_meta.cc    = cc_wide[COL_W-1:0];
        s0_meta.cr    = cr_fix[ROW_W-1:0];
        s0_meta.valid = (cc_wide >= CFG_W_W'(2)) && (cc_wide <= w_eff - CFG_W_W'(3))
                        && (cr_fix >= 2)
                        && (cr_fix <= $signed({2'b00, h_eff}) - (ROW_W+2)'(3));
        s0_meta.last  = row_end && frame_end;

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line ram: four rows packed in one word per column ----------------
    logic                 ram_we;
    logic [COL_W-1:0]     ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [RAM_W-1:0]     ram_rdata;

    ffb5_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1: column assembly and write-back ----------------
    logic             s1_vld_reg;
    pix_t             s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    meta_t            s1_meta_reg;
    pix_t             colv [WIN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_meta_reg <= s0_meta;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
            colv[i] = ram_rdata[i*PIX_W +: PIX_W];
        colv[LINES] = s1_px_reg;
        // each line moves up by one row, the new pixel enters the bottom line
        for (int i = 0; i < LINES; i++)
            ram_wdata[i*PIX_W +: PIX_W] = colv[i+1];
    end

    assign ram_we    = s1_vld_reg && adv;
    assign ram_waddr = s1_col_reg;

    // ---------------- stage 2: window and per-row partial sums ----------------
    pix_t  win_reg [WIN][WIN];
    logic  s2_vld_reg;
    meta_t s2_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WIN; r++)
                for (int c = 0; c < WIN; c++)
                    win_reg[r][c] <= '0;
        end
        else if (ram_we)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN-1; c++)
                    win_reg[r][c] <= win_reg[r][c+1];
                win_reg[r][WIN-1] <= colv[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_meta_reg <= s1_meta_reg;
    end

    psum_t pu [WIN], pv [WIN], pb [WIN], pc [WIN];

    always_comb
    begin
        for (int r = 0; r < WIN; r++)
        begin
            pu[r] = '0;
            pv[r] = '0;
            pb[r] = '0;
            pc[r] = '0;
            for (int c = 0; c < WIN; c++)
            begin
                pu[r] = pu[r] + SUM_W'(K_GRAD_U[r*WIN+c]  * int'(win_reg[r][c]));
                pv[r] = pv[r] + SUM_W'(K_GRAD_V[r*WIN+c]  * int'(win_reg[r][c]));
                pb[r] = pb[r] + SUM_W'(K_BLOB[r*WIN+c]    * int'(win_reg[r][c]));
                pc[r] = pc[r] + SUM_W'(K_CHECKER[r*WIN+c] * int'(win_reg[r][c]));
            end
        end
    end

    // ---------------- stage 3: row totals and gradient mapping ----------------
    logic  s3_vld_reg;
    meta_t s3_meta_reg;
    psum_t s3_pu_reg [WIN], s3_pv_reg [WIN], s3_pb_reg [WIN], s3_pc_reg [WIN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_pu_reg   <= pu;
            s3_pv_reg   <= pv;
            s3_pb_reg   <= pb;
            s3_pc_reg   <= pc;
        end
    end

    function automatic pix_t grad_map(input psum_t sum);
        psum_t q;
        psum_t biased;
        // divide by 128 rounding toward zero
        q = (sum < 0) ? ((sum + psum_t'(127)) >>> 7) : (sum >>> 7);
        biased = q + psum_t'(128);
        if (biased < 0)
            return '0;
        else if (biased > psum_t'(255))
            return pix_t'(255);
        else
            return biased[PIX_W-1:0];
    endfunction

    psum_t su, sv, sb, sc;
    pix_t  gu, gv;

    always_comb
    begin
        su = '0;
        sv = '0;
        sb = '0;
        sc = '0;
        for (int r = 0; r < WIN; r++)
        begin
            su = su + s3_pu_reg[r];
            sv = sv + s3_pv_reg[r];
            sb = sb + s3_pb_reg[r];
            sc = sc + s3_pc_reg[r];
        end
        gu = grad_map(su);
        gv = grad_map(sv);
    end

    // ---------------- output register ----------------
    logic [63:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg[63]    <= 1'b0;
            out_data_reg[62:51] <= s3_meta_reg.cr;
            out_data_reg[50:41] <= s3_meta_reg.cc;
            if (s3_meta_reg.valid)
            begin
                out_data_reg[7:0]   <= gu;
                out_data_reg[15:8]  <= gv;
                out_data_reg[28:16] <= sb[12:0];
                out_data_reg[40:29] <= sc[11:0];
            end
            else
            begin
                out_data_reg[7:0]   <= 8'd128;
                out_data_reg[15:8]  <= 8'd128;
                out_data_reg[28:16] <= '0;
                out_data_reg[40:29] <= '0;
            end
            out_user_reg <= s3_meta_reg.valid;
            out_last_reg <= s3_meta_reg.last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    // read of the next column never collides with the write-back of the previous one
    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && accept) |-> (ram_waddr != col_reg))
        else $error("line ram read and write hit the same column");

    // a window flagged valid never has its centre on the first two rows or columns
    a_valid_centre: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[50:41] >= 10'd2 && m_tdata[62:51] >= 12'd2))
        else $error("valid window centre inside the border");

    // counters only move on an accepted beat
    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position counters moved without an input beat");

endmodule

`default_nettype wire

/* design/ffb5_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// standalone; used for the line store of the filter bank
`default_nettype none

module ffb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking bench for feature_filter_bank_5x5_top: a scoreboard mirrors the line
// stores, the 5x5 window and the four kernels and checks every result beat field by field
// depends on ffb5_pkg and the design sources
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [7:0]  grad_u;
        logic [7:0]  grad_v;
        logic [12:0] blob_sum;
        logic [11:0] chess_sum;
        logic [9:0]  center_col;
        logic [11:0] center_row;
        logic        window_valid;
        logic        frame_last;
    } filter_response_t;

    class filter_scoreboard;
        logic [7:0] line_mem [4][ffb5_pkg::MAX_WIDTH];
        int col_writes [ffb5_pkg::MAX_WIDTH];
        logic [7:0] window [25];
        int col_pos;
        int row_pos;
        logic [10:0] width_reg;
        logic [11:0] height_reg;
        filter_response_t pending_responses [$];
        int mismatches;
        int results_seen;

        function new();
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < ffb5_pkg::MAX_WIDTH; j++)
                    line_mem[i][j] = '0;
            for (int j = 0; j < ffb5_pkg::MAX_WIDTH; j++)
                col_writes[j] = 0;
            for (int i = 0; i < 25; i++)
                window[i] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = 11'd1024;
            height_reg = 12'd284;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function int width_in_use();
            if (width_reg < 5)
                return 5;
            if (width_reg > ffb5_pkg::MAX_WIDTH)
                return ffb5_pkg::MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int height_in_use();
            return (height_reg < 5) ? 5 : int'(height_reg);
        endfunction

        // width that a register value would put in use
        function int clamp_width(logic [11:0] value);
            if (value[10:0] < 5)
                return 5;
            if (value[10:0] > ffb5_pkg::MAX_WIDTH)
                return ffb5_pkg::MAX_WIDTH;
            return int'(value[10:0]);
        endfunction

        // columns from zero up that have taken four writes, so all their lines hold pixels
        function int filled_width();
            int n;
            n = 0;
            while (n < ffb5_pkg::MAX_WIDTH && col_writes[n] >= 4)
                n++;
            return n;
        endfunction

        function void set_register(logic index, logic [11:0] value);
            if (index == ffb5_pkg::CFG_IMAGE_WIDTH)
                width_reg = value[10:0];
            else
                height_reg = value;
        endfunction

        // beats still to go up to and including the frame's last pixel
        function int pixels_left();
            int w;
            int h;
            int row_tail;
            w = width_in_use();
            h = height_in_use();
            row_tail = (col_pos + 1 >= w) ? 1 : w - col_pos;
            if (row_pos + 1 >= h)
                return row_tail;
            return row_tail + (h - 1 - row_pos) * w;
        endfunction

        // binomial smoothing and derivative taps; the sobel kernels are their outer products
        function int smooth_tap(int i);
            case (i)
                0, 4:    return 1;
                1, 3:    return 4;
                default: return 6;
            endcase
        endfunction

        function int deriv_tap(int i);
            case (i)
                0:       return 1;
                1:       return 2;
                2:       return 0;
                3:       return -2;
                default: return -1;
            endcase
        endfunction

        function logic [7:0] offset_grad(int s);
            int q;
            q = s / 128 + 128;
            if (q < 0)
                q = 0;
            if (q > 255)
                q = 255;
            return q[7:0];
        endfunction

        function void note_pixel(logic [7:0] px);
            logic [7:0] column [5];
            int w;
            int h;
            int c;
            int cc;
            int cr;
            int u_acc;
            int v_acc;
            int blob_acc;
            int chess_acc;
            int p;
            int sr;
            int sk;
            int wb;
            filter_response_t resp;
            w = width_in_use();
            h = height_in_use();
            c = col_pos;
            for (int i = 0; i < 4; i++)
                column[i] = line_mem[i][c];
            column[4] = px;
            for (int i = 0; i < 4; i++)
                line_mem[i][c] = column[i + 1];
            col_writes[c]++;
            for (int r = 0; r < 5; r++)
            begin
                for (int k = 0; k < 4; k++)
                    window[r * 5 + k] = window[r * 5 + k + 1];
                window[r * 5 + 4] = column[r];
            end
            // the first two columns of a row finish off the previous row
            if (c >= 2)
            begin
                cc = c - 2;
                cr = row_pos - 2;
            end
            else
            begin
                cc = c + w - 2;
                cr = row_pos - 3;
            end
            if (cr < 0)
                cr += h;
            resp.window_valid = (cc >= 2 && cc <= w - 3 && cr >= 2 && cr <= h - 3);
            resp.frame_last = (c + 1 >= w) && (row_pos + 1 >= h);
            u_acc = 0;
            v_acc = 0;
            blob_acc = 0;
            chess_acc = 0;
            if (resp.window_valid)
            begin
                for (int r = 0; r < 5; r++)
                    for (int k = 0; k < 5; k++)
                    begin
                        p = int'(window[r * 5 + k]);
                        u_acc += p * smooth_tap(r) * deriv_tap(k);
                        v_acc += p * deriv_tap(r) * smooth_tap(k);
                        wb = (r == 0 || r == 4 || k == 0 || k == 4) ? -1 :
                             ((r == 2 && k == 2) ? 8 : 1);
                        blob_acc += p * wb;
                        sr = (r < 2) ? -1 : ((r > 2) ? 1 : 0);
                        sk = (k < 2) ? -1 : ((k > 2) ? 1 : 0);
                        chess_acc -= p * sr * sk;
                    end
            end
            resp.grad_u = resp.window_valid ? offset_grad(u_acc) : 8'd128;
            resp.grad_v = resp.window_valid ? offset_grad(v_acc) : 8'd128;
            resp.blob_sum = blob_acc[12:0];
            resp.chess_sum = chess_acc[11:0];
            resp.center_col = cc[9:0];
            resp.center_row = cr[11:0];
            pending_responses.push_back(resp);
            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch @%0t: %s", $time, what);
        endtask

        task check_field(string name, string where, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s at %s: got %0h expected %0h",
                                          name, where, got, want));
        endtask

        task check_result(logic [63:0] beat, logic user, logic last);
            filter_response_t want;
            string where;
            results_seen++;
            if (pending_responses.size() == 0)
            begin
                report_mismatch("result beat with no pixel waiting");
                return;
            end
            want = pending_responses.pop_front();
            where = $sformatf("row %0d col %0d", want.center_row, want.center_col);
            check_field("grad_u", where, beat[7:0], want.grad_u);
            check_field("grad_v", where, beat[15:8], want.grad_v);
            check_field("blob_response", where, beat[28:16], want.blob_sum);
            check_field("checker_response", where, beat[40:29], want.chess_sum);
            check_field("center_col", where, beat[50:41], want.center_col);
            check_field("center_row", where, beat[62:51], want.center_row);
            check_field("pad", where, beat[63], 1'b0);
            check_field("window_valid", where, user, want.window_valid);
            check_field("frame_last", where, last, want.frame_last);
        endtask

        task leftover_check();
            if (pending_responses.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_responses.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [ffb5_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    int src_idle = 0;
    int sink_stall = 0;
    int sent_count = 0;
    filter_scoreboard sb;

    feature_filter_bank_5x5_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall);

    // both handshakes are sampled with the values that stood before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    function logic [7:0] random_pixel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.results_seen < sent_count)
            @(posedge clk);
    endtask

    // writes both registers back to back, valid held high across the pair
    task automatic configure(input logic [11:0] w, input logic [11:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= ffb5_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(ffb5_pkg::CFG_IMAGE_WIDTH, w);
        cfg_index <= ffb5_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(ffb5_pkg::CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase_items;
        int pick;
        int count;
        logic [11:0] w_val;
        logic [11:0] h_val;
        sb = new();
        w_val = 12'd5;
        h_val = 12'd5;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // undersized geometry clamps to 5x5; bright 3x3 core drives the blob sum to its top
        configure(12'd0, 12'd0);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_pixel((r >= 1 && r <= 3 && c >= 1 && c <= 3) ? 8'd255 : 8'd0);

        // shrink the geometry mid-frame so both counters sit past the new limits
        drain;
        configure(12'd16, 12'd9);
        repeat (16 * 7 + 10) send_pixel(random_pixel());
        drain;
        configure(12'd6, 12'd5);
        count = sb.pixels_left();
        repeat (count) send_pixel(random_pixel());

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle = 0;
                    sink_stall = 0;
                end
                1:
                begin
                    src_idle = 79;
                    sink_stall = 0;
                end
                2:
                begin
                    src_idle = 0;
                    sink_stall = 79;
                end
                default:
                begin
                    src_idle = 19;
                    sink_stall = 19;
                end
            endcase
            phase_items = 0;
            while (phase_items < 75)
            begin
                drain;
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    w_val = 12'($urandom_range(5, 12));
                    h_val = 12'($urandom_range(5, 9));
                end
                else if (pick < 80)
                begin
                    w_val = 12'($urandom_range(0, 4));
                    h_val = 12'($urandom_range(0, 4));
                end
                else if (pick < 90)
                begin
                    w_val = 12'($urandom_range(0, 4095));
                    h_val = 12'($urandom_range(0, 4095));
                end
                // part way through a frame, only widen onto columns whose lines all hold pixels
                if ((sb.col_pos != 0 || sb.row_pos != 0)
                    && sb.clamp_width(w_val) > sb.filled_width())
                    w_val = 12'(sb.filled_width());
                configure(w_val, h_val);
                // mostly run to the end of the frame, sometimes stop part way
                count = sb.pixels_left();
                if (count > 150 || $urandom_range(9) < 3)
                    count = $urandom_range(1, 40);
                repeat (count) send_pixel(random_pixel());
                phase_items += count;
            end
        end

        drain;
        repeat (8) @(posedge clk);
        sb.leftover_check();
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
